// ===== sv/sbps_pkg.sv =====
// Shared types and constants for the score bucket priority stack.
`timescale 1ns / 1ps
`default_nettype none
package sbps_pkg;

  localparam int NumBuckets  = 64;
  localparam int BucketDepth = 16;
  localparam int MaxPosition = 255;

  localparam int BktW       = $clog2(NumBuckets);
  localparam int BestW      = $clog2(NumBuckets + 1);
  localparam int FillW      = $clog2(BucketDepth + 1);
  localparam int SlotW      = (BucketDepth > 1) ? $clog2(BucketDepth) : 1;
  localparam int EntryAw    = BktW + SlotW;
  localparam int EntryDepth = NumBuckets * (2 ** SlotW);
  localparam int ScoreW     = 11;
  localparam int NumGroups  = (NumBuckets + 7) / 8;
  localparam int GrpW       = (NumGroups > 1) ? $clog2(NumGroups) : 1;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_CLEAR = 2'd2
  } opcode_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2,
    STAT_RANGE = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CFG_MM   = 2'd0,
    CFG_GAPO = 2'd1,
    CFG_GAPE = 2'd2
  } cfg_e;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  position;
    logic [31:0] interval_low;
    logic [31:0] interval_high;
    logic [3:0]  mismatches;
    logic [3:0]  gap_opens;
    logic [3:0]  gap_extends;
    logic [3:0]  insertions;
    logic [3:0]  deletions;
    logic [1:0]  align_state;
    logic        is_diff;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  out_score;
    logic [7:0]  out_position;
    logic [31:0] out_interval_low;
    logic [31:0] out_interval_high;
    logic [3:0]  out_mismatches;
    logic [3:0]  out_gap_opens;
    logic [3:0]  out_gap_extends;
    logic [3:0]  out_insertions;
    logic [3:0]  out_deletions;
    logic [1:0]  out_state;
    logic [7:0]  out_last_diff;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic latch;
    logic fill_rd;
    logic exec;
    logic load_out;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_busy;
  } stat_t;

endpackage
`default_nettype wire

// ===== sv/sbps_ctrl.sv =====
// Sequencing state machine: accept, bucket fill read, execute, respond.
`timescale 1ns / 1ps
`default_nettype none
module sbps_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  output sbps_pkg::cmd_t     cmd_o,
  input  wire sbps_pkg::stat_t stat_i
);
  import sbps_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_FILL = 4'b0010,
    S_EXEC = 4'b0100,
    S_RESP = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_FILL;
        end
      end
      S_FILL: begin
        cmd_o.fill_rd = 1'b1;
        state_d       = S_EXEC;
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = S_RESP;
      end
      S_RESP: begin
        if (!stat_i.out_busy) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign in_stall_o = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

// ===== sv/sbps_datapath.sv =====
// Datapath: penalty registers, bucket fill and entry memories, best bucket search.
`timescale 1ns / 1ps
`default_nettype none
module sbps_datapath (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire sbps_pkg::in_item_t  in_item_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output sbps_pkg::out_item_t      out_item_o,
  input  wire logic                cfg_we_i,
  input  wire logic [1:0]          cfg_idx_i,
  input  wire logic [4:0]          cfg_data_i,
  input  wire sbps_pkg::cmd_t      cmd_i,
  output sbps_pkg::stat_t          stat_o
);
  import sbps_pkg::*;

  typedef struct packed {
    logic [31:0] ilow;
    logic [31:0] ihigh;
    logic [7:0]  pos;
    logic [3:0]  mm;
    logic [3:0]  go;
    logic [3:0]  ge;
    logic [3:0]  ins;
    logic [3:0]  del;
    logic [1:0]  st;
    logic [7:0]  ldiff;
  } entry_t;

  // penalties
  logic [4:0] mm_pen_q, gapo_pen_q, gape_pen_q;

  // latched transaction
  in_item_t          item_q;
  logic [ScoreW-1:0] score_q;

  // storage
  logic [FillW-1:0]  fill_mem [NumBuckets];
  entry_t            ent_mem  [EntryDepth];
  logic [NumBuckets-1:0] flags_q;

  logic [BktW-1:0]   bkt_sel, bkt_q;
  logic [FillW-1:0]  fill_rd_q;
  logic              flag_rd_q;

  logic [BestW-1:0]  best_q, best_d;
  logic              any_q;

  // execute-stage controls
  logic [FillW-1:0]   fill_eff, fill_dec, fill_wdata;
  logic               fill_we, ent_we, ent_re;
  logic [SlotW-1:0]   slot;
  logic [EntryAw-1:0] ent_addr;
  logic               flag_set, flag_clr, flags_clr_all;
  entry_t             ent_wdata, ent_rd_q;
  logic [7:0]         pos_sat;
  logic [1:0]         res_status_d, res_status_q;
  logic [5:0]         res_score_d, res_score_q;
  logic               res_pop_d, res_pop_q;

  // best bucket search
  logic [NumGroups*8-1:0] flags_pad;
  logic [NumGroups-1:0]   grp_or;
  logic [GrpW-1:0]        grp_sel;
  logic [7:0]             grp_bits;
  logic [2:0]             bit_sel;

  out_item_t out_d, out_q;
  logic      out_valid_q;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mm_pen_q   <= 5'd3;
      gapo_pen_q <= 5'd11;
      gape_pen_q <= 5'd4;
    end else if (cfg_we_i) begin
      unique case (cfg_e'(cfg_idx_i))
        CFG_MM:   mm_pen_q   <= cfg_data_i;
        CFG_GAPO: gapo_pen_q <= cfg_data_i;
        CFG_GAPE: gape_pen_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- latch
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      item_q  <= in_item_i;
      score_q <= ScoreW'(in_item_i.mismatches) * ScoreW'(mm_pen_q)
               + ScoreW'(in_item_i.gap_opens) * ScoreW'(gapo_pen_q)
               + ScoreW'(in_item_i.gap_extends) * ScoreW'(gape_pen_q);
    end
  end

  // ---------------------------------------------------------------- fill memory
  assign bkt_sel = (opcode_e'(item_q.opcode) == OP_POP) ? best_q[BktW-1:0]
                                                         : score_q[BktW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.fill_rd) begin
      fill_rd_q <= fill_mem[bkt_sel];
      flag_rd_q <= flags_q[bkt_sel];
      bkt_q     <= bkt_sel;
    end
    if (fill_we) begin
      fill_mem[bkt_q] <= fill_wdata;
    end
  end

  // ---------------------------------------------------------------- execute
  // an empty bucket's flag is low, so its stale fill count is ignored
  assign fill_eff = flag_rd_q ? fill_rd_q : '0;
  assign fill_dec = fill_eff - FillW'(1);
  assign pos_sat  = (item_q.position > MaxPosition) ? 8'(MaxPosition) : item_q.position;

  always_comb begin
    ent_wdata.ilow  = item_q.interval_low;
    ent_wdata.ihigh = item_q.interval_high;
    ent_wdata.pos   = pos_sat;
    ent_wdata.mm    = item_q.mismatches;
    ent_wdata.go    = item_q.gap_opens;
    ent_wdata.ge    = item_q.gap_extends;
    ent_wdata.ins   = item_q.insertions;
    ent_wdata.del   = item_q.deletions;
    ent_wdata.st    = item_q.align_state;
    ent_wdata.ldiff = item_q.is_diff ? pos_sat : 8'd0;
  end

  always_comb begin
    fill_we       = 1'b0;
    fill_wdata    = fill_eff;
    ent_we        = 1'b0;
    ent_re        = 1'b0;
    slot          = fill_eff[SlotW-1:0];
    flag_set      = 1'b0;
    flag_clr      = 1'b0;
    flags_clr_all = 1'b0;
    res_status_d  = STAT_OK;
    res_score_d   = '0;
    res_pop_d     = 1'b0;
    unique case (opcode_e'(item_q.opcode))
      OP_PUSH: begin
        if (score_q >= ScoreW'(NumBuckets)) begin
          res_status_d = STAT_RANGE;
        end else if (fill_eff == FillW'(BucketDepth)) begin
          res_status_d = STAT_FULL;
          res_score_d  = 6'(bkt_q);
        end else begin
          res_score_d = 6'(bkt_q);
          fill_we     = cmd_i.exec;
          fill_wdata  = fill_eff + FillW'(1);
          ent_we      = cmd_i.exec;
          flag_set    = cmd_i.exec;
        end
      end
      OP_POP: begin
        if (!any_q) begin
          res_status_d = STAT_EMPTY;
        end else begin
          res_score_d = 6'(bkt_q);
          res_pop_d   = 1'b1;
          slot        = fill_dec[SlotW-1:0];
          fill_we     = cmd_i.exec;
          fill_wdata  = fill_dec;
          ent_re      = cmd_i.exec;
          flag_clr    = cmd_i.exec && (fill_dec == '0);
        end
      end
      OP_CLEAR: begin
        flags_clr_all = cmd_i.exec;
      end
      default: ;
    endcase
  end

  assign ent_addr = {bkt_q, slot};

  always_ff @(posedge clk_i) begin
    if (ent_we) begin
      ent_mem[ent_addr] <= ent_wdata;
    end
    if (ent_re) begin
      ent_rd_q <= ent_mem[ent_addr];
    end
    if (cmd_i.exec) begin
      res_status_q <= res_status_d;
      res_score_q  <= res_score_d;
      res_pop_q    <= res_pop_d;
    end
  end

  // ---------------------------------------------------------------- nonempty flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
    end else if (flags_clr_all) begin
      flags_q <= '0;
    end else if (flag_set) begin
      flags_q[bkt_q] <= 1'b1;
    end else if (flag_clr) begin
      flags_q[bkt_q] <= 1'b0;
    end
  end

  // lowest nonempty bucket: first group of eight, then bit within it
  assign flags_pad = (NumGroups*8)'(flags_q);

  always_comb begin
    for (int g = 0; g < NumGroups; g++) begin
      grp_or[g] = |flags_pad[g*8 +: 8];
    end
    grp_sel = '0;
    for (int g = NumGroups - 1; g >= 0; g--) begin
      if (grp_or[g]) grp_sel = GrpW'(g);
    end
    grp_bits = flags_pad[grp_sel*8 +: 8];
    bit_sel  = '0;
    for (int b = 7; b >= 0; b--) begin
      if (grp_bits[b]) bit_sel = 3'(b);
    end
    best_d = (|grp_or) ? BestW'({grp_sel, bit_sel}) : BestW'(NumBuckets);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_q <= BestW'(NumBuckets);
      any_q  <= 1'b0;
    end else begin
      best_q <= best_d;
      any_q  <= |flags_q;
    end
  end

  // ---------------------------------------------------------------- result
  always_comb begin
    out_d           = '0;
    out_d.status    = res_status_q;
    out_d.out_score = res_score_q;
    if (res_pop_q) begin
      out_d.out_position      = ent_rd_q.pos;
      out_d.out_interval_low  = ent_rd_q.ilow;
      out_d.out_interval_high = ent_rd_q.ihigh;
      out_d.out_mismatches    = ent_rd_q.mm;
      out_d.out_gap_opens     = ent_rd_q.go;
      out_d.out_gap_extends   = ent_rd_q.ge;
      out_d.out_insertions    = ent_rd_q.ins;
      out_d.out_deletions     = ent_rd_q.del;
      out_d.out_state         = ent_rd_q.st;
      out_d.out_last_diff     = ent_rd_q.ldiff;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_item_o      = out_q;
  assign stat_o.out_busy = out_valid_q && out_stall_i;

endmodule
`default_nettype wire

// ===== sv/score_bucket_priority_stack_core.sv =====
// Score bucket priority stack: top level joining controller and datapath.
//
// Input channel (in_valid_i / in_stall_o / in_item_i) takes one transaction:
// push an entry, pop the best entry, or clear the store. Every transaction
// gives exactly one result on the output channel (out_valid_o / out_stall_i /
// out_item_o) carrying a status code and, for a pop, the entry's fields.
// A push lands in the bucket given by its weighted penalty score; a pop takes
// the newest entry of the lowest nonempty bucket.
// A transaction passes through accept, bucket fill memory read, execute (fill
// write plus entry memory access) and response, one state each, as the fill
// and entry memories have one port; a new transaction is accepted only once
// the previous one has left its response state.
// The penalty registers are written through cfg_we_i / cfg_idx_i / cfg_data_i;
// the user must write them only while the block is idle (not enforced here).
// Reset empties every bucket at once (nonempty flags cleared) and restores the
// default penalties; no clearing pass is needed. If the receiver stalls, the
// result holds in the output register and the next transaction may already be
// accepted; it then waits in its response state until the register frees.
`timescale 1ns / 1ps
`default_nettype none
module score_bucket_priority_stack_core (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire sbps_pkg::in_item_t  in_item_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output sbps_pkg::out_item_t      out_item_o,
  input  wire logic                cfg_we_i,
  input  wire logic [1:0]          cfg_idx_i,
  input  wire logic [4:0]          cfg_data_i
);
  import sbps_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  sbps_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd),
    .stat_i     (stat)
  );

  sbps_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat)
  );

endmodule
`default_nettype wire

// ===== sv/sbps_checker.sv =====
// Port-level checks for the score bucket priority stack, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module sbps_checker (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  input  wire logic                in_stall_o,
  input  wire sbps_pkg::in_item_t  in_item_i,
  input  wire logic                out_valid_o,
  input  wire logic                out_stall_i,
  input  wire sbps_pkg::out_item_t out_item_o,
  input  wire logic                cfg_we_i,
  input  wire logic [1:0]          cfg_idx_i,
  input  wire logic [4:0]          cfg_data_i
);
  import sbps_pkg::*;

  // one transaction in flight: stall rises right after an accept
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input accepted while previous transaction still in flight");

  // empty pop carries nothing else
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.status == STAT_EMPTY) |->
      (out_item_o.out_score == 6'd0 && out_item_o.out_position == 8'd0 &&
       out_item_o.out_interval_low == 32'd0 && out_item_o.out_last_diff == 8'd0))
    else $error("empty pop result has nonzero fields");

  // out of range push reports score zero
  a_range_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.status == STAT_RANGE) |-> (out_item_o.out_score == 6'd0))
    else $error("out of range result has nonzero score");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> $stable(out_item_o))
    else $error("stalled result changed");

endmodule

bind score_bucket_priority_stack_core sbps_checker u_sbps_checker (.*);
`default_nettype wire
